FILE: rtl/core/lfce_pkg.sv
// Package for the LIN frame checksum engine: operation and status codes,
// descriptor and transaction types, protected identifier function.
// No dependencies.
`default_nettype none

package lfce_pkg;

   localparam int unsigned DEF_TABLE_ENTRIES  = 64;
   localparam int unsigned DEF_MAX_DATA_BYTES = 8;

   // Identifiers that come out of reset with a full-length descriptor
   localparam logic [7:0] RESET_ID_PLAIN   = 8'd60;
   localparam logic [7:0] RESET_ID_REQUEST = 8'd61;
   localparam logic [3:0] RESET_LENGTH     = 4'd8;

   typedef enum logic [1:0] {
      OP_CONFIG   = 2'd0,
      OP_HEADER   = 2'd1,
      OP_DATA     = 2'd2,
      OP_CHECKSUM = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_ID    = 3'd1,
      ST_NOT_OPEN  = 3'd2,
      ST_TOO_MANY  = 3'd3,
      ST_TOO_FEW   = 3'd4,
      ST_MISMATCH  = 3'd5
   } status_type;

   // Frame descriptor, laid out as stored: length in the top four bits
   typedef struct packed {
      logic [3:0] length;
      logic       in_use;
      logic       enhanced;
      logic       request;
   } entry_type;

   // Fields that travel with a transaction into the lookup stage
   typedef struct packed {
      op_type     op;
      logic [7:0] frame_id;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      status_type status;
      logic       is_request;
      logic       is_enhanced;
      logic       is_in_use;
      logic [3:0] frame_length;
      logic [7:0] checksum_value;
      logic       checksum_ok;
   } rsp_type;

   // LIN protected identifier: parity bits P0 and P1 above the 6-bit id
   function automatic logic [7:0] protected_id(input logic [5:0] id);
      logic p0;
      logic p1;
      p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
      p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
      return {p1, p0, id};
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/lin_frame_checksum_engine.sv
// Top level of the LIN frame checksum engine: accept stage, descriptor
// table, frame tracker and response register. Depends on lfce_pkg,
// lfce_table and lfce_frame.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------------
//   req_    | in        | req_valid / req_ready | op, frame_id, data_byte, set_*
//   rsp_    | out       | rsp_valid / rsp_ready | status, is_*, frame_length, checksum_*
//
// One transaction per cycle sustained while responses are taken. The table is
// read at the accept edge into the lookup stage, and the response register
// loads from the lookup stage when it fires, so a result passes both on its way
// to rsp_. Configure writes land at accept, so a header right behind a configure
// sees the new descriptor. Reset clears the per-entry written flags.
// A stalled response holds the lookup stage; req_ready drops only then.
`default_nettype none

module lin_frame_checksum_engine #(
   parameter int unsigned TABLE_ENTRIES  = lfce_pkg::DEF_TABLE_ENTRIES,
   parameter int unsigned MAX_DATA_BYTES = lfce_pkg::DEF_MAX_DATA_BYTES
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [1:0]  req_op,
   input  wire  [7:0]  req_frame_id,
   input  wire  [7:0]  req_data_byte,
   input  wire         req_set_request,
   input  wire         req_set_enhanced,
   input  wire         req_set_in_use,
   input  wire  [3:0]  req_set_length,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [2:0]  rsp_status,
   output logic        rsp_is_request,
   output logic        rsp_is_enhanced,
   output logic        rsp_is_in_use,
   output logic [3:0]  rsp_frame_length,
   output logic [7:0]  rsp_checksum_value,
   output logic        rsp_checksum_ok
);
   import lfce_pkg::*;

   localparam int unsigned IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [8:0]  ENTRIES_LIMIT = 9'(TABLE_ENTRIES);
   localparam logic [3:0]  MAX_LEN = 4'(MAX_DATA_BYTES);

   logic       accept;
   logic       advance;
   logic       fire;
   op_type     in_op;
   logic       cfg_write;
   entry_type  cfg_entry;
   entry_type  mem_entry;
   logic       mem_written;
   rsp_type    result;

   logic       s1_valid_ff, s1_valid_in;
   req_type    s1_req_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff;

   assign in_op   = op_type'(req_op);
   // Response register free or draining this cycle
   assign advance = !rsp_valid_ff || rsp_ready;
   assign fire    = s1_valid_ff && advance;
   assign req_ready = !s1_valid_ff || advance;
   assign accept  = req_valid && req_ready;

   // Configure: write at accept, length saturated, bad ids dropped
   assign cfg_write = accept && (in_op == OP_CONFIG) &&
                      ({1'b0, req_frame_id} < ENTRIES_LIMIT);
   always_comb begin
      cfg_entry          = '0;
      cfg_entry.request  = req_set_request;
      cfg_entry.enhanced = req_set_enhanced;
      cfg_entry.in_use   = req_set_in_use;
      cfg_entry.length   = (req_set_length > MAX_LEN) ? MAX_LEN : req_set_length;
   end

   lfce_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (accept),
      .rd_idx     (req_frame_id[IDX_W-1:0]),
      .wr_en      (cfg_write),
      .wr_idx     (req_frame_id[IDX_W-1:0]),
      .wr_data    (cfg_entry),
      .rd_data    (mem_entry),
      .rd_written (mem_written)
   );

   lfce_frame #(
      .TABLE_ENTRIES  (TABLE_ENTRIES),
      .MAX_DATA_BYTES (MAX_DATA_BYTES)
   ) u_frame (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .req         (s1_req_ff),
      .mem_entry   (mem_entry),
      .mem_written (mem_written),
      .result      (result)
   );

   // Lookup stage: hold while the response register is stalled
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff.op        <= in_op;
         s1_req_ff.frame_id  <= req_frame_id;
         s1_req_ff.data_byte <= req_data_byte;
      end
   end

   // Response register: load on fire, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_is_request     = rsp_ff.is_request;
   assign rsp_is_enhanced    = rsp_ff.is_enhanced;
   assign rsp_is_in_use      = rsp_ff.is_in_use;
   assign rsp_frame_length   = rsp_ff.frame_length;
   assign rsp_checksum_value = rsp_ff.checksum_value;
   assign rsp_checksum_ok    = rsp_ff.checksum_ok;

`ifndef SYNTHESIS
   // Back pressure only when both stages hold a transaction
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("req_ready low with a free stage");

   // An accepted transaction reaches the lookup stage
   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted transaction lost before lookup");

   // A matching checksum always reports ok status
   a_ok_consistent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_checksum_ok) |-> (rsp_status == ST_OK))
      else $error("checksum_ok with non-ok status");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/lfce_table.sv
// Descriptor table: synchronous memory with one write and one registered
// read port, plus per-entry written flags. Depends on lfce_pkg.
`default_nettype none

module lfce_table #(
   parameter int unsigned TABLE_ENTRIES = lfce_pkg::DEF_TABLE_ENTRIES
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  rd_en,
   input  wire  [((TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1)-1:0] rd_idx,
   input  wire                  wr_en,
   input  wire  [((TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1)-1:0] wr_idx,
   input  lfce_pkg::entry_type  wr_data,
   output lfce_pkg::entry_type  rd_data,
   output logic                 rd_written
);
   import lfce_pkg::*;

   entry_type               mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] written_ff;
   entry_type               rd_data_ff;
   logic                    rd_written_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff    <= mem[rd_idx];
         rd_written_ff <= written_ff[rd_idx];
      end
   end

   // Unwritten entries read as their reset descriptor downstream
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr_en) begin
         written_ff[wr_idx] <= 1'b1;
      end
   end

   assign rd_data    = rd_data_ff;
   assign rd_written = rd_written_ff;

endmodule

`default_nettype wire

FILE: rtl/core/lfce_frame.sv
// Frame tracker: open-frame state, end-around-carry accumulator and the
// result of each transaction in the lookup stage. Depends on lfce_pkg.
`default_nettype none

module lfce_frame #(
   parameter int unsigned TABLE_ENTRIES  = lfce_pkg::DEF_TABLE_ENTRIES,
   parameter int unsigned MAX_DATA_BYTES = lfce_pkg::DEF_MAX_DATA_BYTES
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  fire,
   input  lfce_pkg::req_type    req,
   input  lfce_pkg::entry_type  mem_entry,
   input  wire                  mem_written,
   output lfce_pkg::rsp_type    result
);
   import lfce_pkg::*;

   localparam logic [8:0] ENTRIES_LIMIT = 9'(TABLE_ENTRIES);
   localparam logic [3:0] RST_LEN =
      (MAX_DATA_BYTES < 8) ? 4'(MAX_DATA_BYTES) : RESET_LENGTH;

   logic [7:0] acc_ff,   acc_in;
   logic [3:0] seen_ff,  seen_in;
   logic [3:0] len_ff,   len_in;
   logic       open_ff,  open_in;

   logic       id_ok;
   entry_type  entry;
   logic [8:0] sum;
   logic [7:0] folded;
   logic [7:0] inv_sum;

   assign id_ok = ({1'b0, req.frame_id} < ENTRIES_LIMIT);

   // Resolve the descriptor: never-written entries take their reset value
   always_comb begin
      entry = '0;
      if (mem_written) begin
         entry = mem_entry;
      end else if (req.frame_id == RESET_ID_PLAIN) begin
         entry.length = RST_LEN;
      end else if (req.frame_id == RESET_ID_REQUEST) begin
         entry.length  = RST_LEN;
         entry.request = 1'b1;
      end
   end

   assign sum     = {1'b0, acc_ff} + {1'b0, req.data_byte};
   assign folded  = sum[8] ? (sum[7:0] + 8'd1) : sum[7:0];
   assign inv_sum = ~acc_ff;

   always_comb begin
      acc_in  = acc_ff;
      seen_in = seen_ff;
      len_in  = len_ff;
      open_in = open_ff;
      result  = '0;
      result.status = ST_OK;
      unique case (req.op)
         OP_CONFIG: begin
            if (!id_ok) begin
               result.status = ST_BAD_ID;
            end
         end
         OP_HEADER: begin
            if (!id_ok) begin
               open_in       = 1'b0;
               result.status = ST_BAD_ID;
            end else begin
               open_in             = 1'b1;
               seen_in             = '0;
               len_in              = entry.length;
               acc_in              = entry.enhanced ? protected_id(req.frame_id[5:0]) : 8'd0;
               result.is_request   = entry.request;
               result.is_enhanced  = entry.enhanced;
               result.is_in_use    = entry.in_use;
               result.frame_length = entry.length;
            end
         end
         OP_DATA: begin
            if (!open_ff) begin
               result.status = ST_NOT_OPEN;
            end else if (seen_ff >= len_ff) begin
               result.status = ST_TOO_MANY;
            end else begin
               acc_in  = folded;
               seen_in = seen_ff + 4'd1;
            end
         end
         OP_CHECKSUM: begin
            if (!open_ff) begin
               result.status = ST_NOT_OPEN;
            end else if (seen_ff < len_ff) begin
               open_in       = 1'b0;
               result.status = ST_TOO_FEW;
            end else begin
               open_in               = 1'b0;
               result.checksum_value = inv_sum;
               result.checksum_ok    = (inv_sum == req.data_byte);
               result.status         = (inv_sum == req.data_byte) ? ST_OK : ST_MISMATCH;
            end
         end
         default: begin
            result.status = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         seen_ff <= '0;
         len_ff  <= '0;
         open_ff <= 1'b0;
      end else if (fire) begin
         acc_ff  <= acc_in;
         seen_ff <= seen_in;
         len_ff  <= len_in;
         open_ff <= open_in;
      end
   end

endmodule

`default_nettype wire

FILE: dv/lfce_frame_checker.sv
// Scoreboard for the LIN frame checksum engine: mirrors the descriptor table
// and the open frame, predicts every response and compares it field by field.
// Depends on lfce_pkg.

module lfce_frame_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_frame_id,
   input  logic [7:0]  req_data_byte,
   input  logic        req_set_request,
   input  logic        req_set_enhanced,
   input  logic        req_set_in_use,
   input  logic [3:0]  req_set_length,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_status,
   input  logic        rsp_is_request,
   input  logic        rsp_is_enhanced,
   input  logic        rsp_is_in_use,
   input  logic [3:0]  rsp_frame_length,
   input  logic [7:0]  rsp_checksum_value,
   input  logic        rsp_checksum_ok,
   input  logic        run_complete,
   output int          error_count
);
   import lfce_pkg::*;

   localparam int unsigned TABLE_SIZE = DEF_TABLE_ENTRIES;
   localparam logic [3:0]  MAX_BYTES  = 4'(DEF_MAX_DATA_BYTES);

   entry_type  descriptor_table [TABLE_SIZE];
   logic [7:0] running_sum;
   logic [3:0] bytes_taken;
   logic [3:0] frame_bytes;
   logic       frame_active;
   rsp_type    pending_frame_results [$];
   int         mismatch_total    = 0;
   logic       leftovers_checked = 1'b0;

   assign error_count = mismatch_total;

   task automatic clear_frame_state();
      foreach (descriptor_table[i])
         descriptor_table[i] = '0;
      descriptor_table[RESET_ID_PLAIN[5:0]].length   = RESET_LENGTH;
      descriptor_table[RESET_ID_REQUEST[5:0]].length  = RESET_LENGTH;
      descriptor_table[RESET_ID_REQUEST[5:0]].request = 1'b1;
      running_sum  = '0;
      bytes_taken  = '0;
      frame_bytes  = '0;
      frame_active = 1'b0;
      pending_frame_results.delete();
   endtask

   function automatic rsp_type compute_frame_response(
      input op_type     op,
      input logic [7:0] id,
      input logic [7:0] value,
      input logic       set_req,
      input logic       set_enh,
      input logic       set_use,
      input logic [3:0] set_len
   );
      rsp_type    result;
      entry_type  desc;
      logic [8:0] wide_sum;
      logic [7:0] inverted;
      result = '0;
      result.status = ST_OK;
      case (op)
         OP_CONFIG: begin
            if (id >= TABLE_SIZE) begin
               result.status = ST_BAD_ID;
            end else begin
               desc.request  = set_req;
               desc.enhanced = set_enh;
               desc.in_use   = set_use;
               desc.length   = (set_len > MAX_BYTES) ? MAX_BYTES : set_len;
               descriptor_table[id[5:0]] = desc;
            end
         end
         OP_HEADER: begin
            if (id >= TABLE_SIZE) begin
               frame_active  = 1'b0;
               result.status = ST_BAD_ID;
            end else begin
               desc         = descriptor_table[id[5:0]];
               frame_active = 1'b1;
               bytes_taken  = '0;
               frame_bytes  = desc.length;
               // enhanced seed: protected identifier, parity P1 on top, P0 below
               running_sum  = desc.enhanced ?
                  {~(id[1] ^ id[3] ^ id[4] ^ id[5]), id[0] ^ id[1] ^ id[2] ^ id[4], id[5:0]} :
                  8'h00;
               result.is_request   = desc.request;
               result.is_enhanced  = desc.enhanced;
               result.is_in_use    = desc.in_use;
               result.frame_length = desc.length;
            end
         end
         OP_DATA: begin
            if (!frame_active) begin
               result.status = ST_NOT_OPEN;
            end else if (bytes_taken >= frame_bytes) begin
               result.status = ST_TOO_MANY;
            end else begin
               wide_sum = {1'b0, running_sum} + {1'b0, value};
               if (wide_sum >= 9'd256)
                  wide_sum = wide_sum - 9'd255;
               running_sum = wide_sum[7:0];
               bytes_taken = bytes_taken + 4'd1;
            end
         end
         default: begin
            if (!frame_active) begin
               result.status = ST_NOT_OPEN;
            end else if (bytes_taken < frame_bytes) begin
               frame_active  = 1'b0;
               result.status = ST_TOO_FEW;
            end else begin
               inverted     = ~running_sum;
               frame_active = 1'b0;
               result.status         = (inverted == value) ? ST_OK : ST_MISMATCH;
               result.checksum_value = inverted;
               result.checksum_ok    = (inverted == value);
            end
         end
      endcase
      return result;
   endfunction

   // Four-state compare so an unknown response bit is flagged
   function automatic void compare_field(input string field, input logic [7:0] wanted,
                                         input logic [7:0] seen);
      if (wanted !== seen) begin
         $error("%s: expected %0d, actual %0d", field, wanted, seen);
         mismatch_total++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type wanted;
      if (reset) begin
         clear_frame_state();
      end else begin
         if (req_valid && req_ready)
            pending_frame_results.push_back(compute_frame_response(op_type'(req_op),
               req_frame_id, req_data_byte, req_set_request, req_set_enhanced,
               req_set_in_use, req_set_length));
         if (rsp_valid && rsp_ready) begin
            if (pending_frame_results.size() == 0) begin
               $error("response arrived with no transaction outstanding");
               mismatch_total++;
            end else begin
               wanted = pending_frame_results.pop_front();
               compare_field("status", wanted.status, rsp_status);
               compare_field("is_request", wanted.is_request, rsp_is_request);
               compare_field("is_enhanced", wanted.is_enhanced, rsp_is_enhanced);
               compare_field("is_in_use", wanted.is_in_use, rsp_is_in_use);
               compare_field("frame_length", wanted.frame_length, rsp_frame_length);
               compare_field("checksum_value", wanted.checksum_value, rsp_checksum_value);
               compare_field("checksum_ok", wanted.checksum_ok, rsp_checksum_ok);
            end
         end
         if (run_complete && !leftovers_checked) begin
            leftovers_checked = 1'b1;
            if (pending_frame_results.size() != 0) begin
               $error("%0d responses never arrived", pending_frame_results.size());
               mismatch_total += pending_frame_results.size();
            end
         end
      end
   end

endmodule

FILE: dv/lin_frame_checksum_engine_test.sv
// Top of the LIN frame checksum engine testbench: clock, reset, request
// stimulus, response back-pressure and verdict. Depends on lfce_pkg,
// lin_frame_checksum_engine and lfce_frame_checker.

module lin_frame_checksum_engine_test;
   import lfce_pkg::*;

   localparam int ITEM_TARGET    = 750;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int DRAIN_INTERVAL = 150;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_MOSTLY,
      READY_RARELY,
      READY_PATTERN
   } ready_mode_type;

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic [1:0]  req_op           = '0;
   logic [7:0]  req_frame_id     = '0;
   logic [7:0]  req_data_byte    = '0;
   logic        req_set_request  = 1'b0;
   logic        req_set_enhanced = 1'b0;
   logic        req_set_in_use   = 1'b0;
   logic [3:0]  req_set_length   = '0;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic [2:0]  rsp_status;
   logic        rsp_is_request;
   logic        rsp_is_enhanced;
   logic        rsp_is_in_use;
   logic [3:0]  rsp_frame_length;
   logic [7:0]  rsp_checksum_value;
   logic        rsp_checksum_ok;
   logic        run_complete     = 1'b0;
   int          error_count;

   // Stimulus bookkeeping
   int          sent_count     = 0;
   int          received_count = 0;
   int          framed_count   = 0;
   int          burst_left     = 0;
   logic        gaps_enabled   = 1'b1;
   // Stimulus-side copy of what was configured, used only to build frames
   // whose byte count and checksum byte are right
   logic [3:0]  plan_length   [DEF_TABLE_ENTRIES];
   logic        plan_enhanced [DEF_TABLE_ENTRIES];

   // Receiver back-pressure state
   ready_mode_type ready_mode       = READY_ALWAYS;
   int             ready_phase_left = 0;
   logic [7:0]     ready_mask       = 8'h01;

   int          stalled_cycles = 0;

   lin_frame_checksum_engine dut (.*);

   lfce_frame_checker frame_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: switch among always-ready, mostly-ready, rarely-ready and a
   // rotating 8-bit mask; mode, phase length and mask are drawn anew per phase
   always @(posedge clock) begin
      if (ready_phase_left == 0) begin
         ready_mode       <= ready_mode_type'($urandom_range(0, 3));
         ready_phase_left <= $urandom_range(16, 160);
         ready_mask       <= 8'($urandom) | 8'h01;
      end else begin
         ready_phase_left <= ready_phase_left - 1;
         ready_mask       <= {ready_mask[0], ready_mask[7:1]};
      end
      case (ready_mode)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_MOSTLY: rsp_ready <= ($urandom_range(0, 3) != 0);
         READY_RARELY: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:      rsp_ready <= ready_mask[0];
      endcase
   end

   // Count responses taken; nonblocking so the stimulus process always sees
   // the count as of the previous edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         received_count <= received_count + 1;
   end

   // Watchdog: end the run when no transaction moves on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stalled_cycles <= 0;
      else
         stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   // Drive one transaction and hold it until accepted. Insert an idle gap at
   // the start of each burst while gaps are enabled.
   task automatic send_transaction(input op_type op, input logic [7:0] id,
                                   input logic [7:0] value, input logic set_req,
                                   input logic set_enh, input logic set_use,
                                   input logic [3:0] set_len);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = gaps_enabled ? $urandom_range(0, 8) : 0;
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_op           <= op;
      req_frame_id     <= id;
      req_data_byte    <= value;
      req_set_request  <= set_req;
      req_set_enhanced <= set_enh;
      req_set_in_use   <= set_use;
      req_set_length   <= set_len;
      do @(posedge clock); while (!req_ready);
      sent_count++;
      if (op == OP_CONFIG && id < DEF_TABLE_ENTRIES) begin
         plan_enhanced[id[5:0]] = set_enh;
         plan_length[id[5:0]]   = (set_len > 4'(DEF_MAX_DATA_BYTES)) ?
                                  4'(DEF_MAX_DATA_BYTES) : set_len;
      end
   endtask

   task automatic send_simple(input op_type op, input logic [7:0] id, input logic [7:0] value);
      send_transaction(op, id, value, 1'b0, 1'b0, 1'b0, 4'd0);
   endtask

   task automatic send_noise();
      send_transaction(op_type'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                       1'($urandom), 1'($urandom), 1'($urandom), 4'($urandom));
   endtask

   // Hold valid low until every outstanding response has been taken
   task automatic wait_for_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (received_count != sent_count);
   endtask

   // One framed sequence: optional configure, header, data bytes, checksum.
   // Mostly well formed; sometimes short, long, abandoned or with a wrong
   // checksum byte, with an occasional configure slipped in mid-frame.
   task automatic send_frame();
      logic [7:0] id;
      logic [7:0] value;
      logic [7:0] sum;
      logic [8:0] wide;
      logic [3:0] len;
      logic       enh;
      int         byte_total;
      int         shape;
      id = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(64, 255)) :
           ($urandom_range(0, 9) == 0)  ? 8'($urandom_range(60, 61)) :
                                          8'($urandom_range(0, 63));
      if ($urandom_range(0, 9) < 4)
         send_transaction(OP_CONFIG, id, 8'($urandom), 1'($urandom), 1'($urandom),
                          1'($urandom), ($urandom_range(0, 7) == 0) ?
                          4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8)));
      send_transaction(OP_HEADER, id, 8'($urandom), 1'($urandom), 1'($urandom),
                       1'($urandom), 4'($urandom));
      // capture what the frame took at its header
      if (id < DEF_TABLE_ENTRIES) begin
         len = plan_length[id[5:0]];
         enh = plan_enhanced[id[5:0]];
      end else begin
         len = '0;
         enh = 1'b0;
      end
      sum = enh ? protected_id(id[5:0]) : 8'h00;
      byte_total = len;
      shape = $urandom_range(0, 19);
      if (shape < 2)
         byte_total = len + $urandom_range(1, 2);
      else if (shape < 4 && len > 0)
         byte_total = len - $urandom_range(1, len);
      for (int i = 0; i < byte_total; i++) begin
         if ($urandom_range(0, 24) == 0)
            send_transaction(OP_CONFIG, ($urandom_range(0, 1) != 0) ? id : 8'($urandom),
                             8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                             4'($urandom));
         case ($urandom_range(0, 9))
            0:       value = 8'h00;
            1:       value = 8'hFF;
            default: value = 8'($urandom);
         endcase
         if (i < len) begin
            wide = {1'b0, sum} + {1'b0, value};
            if (wide[8])
               wide = wide - 9'd255;
            sum = wide[7:0];
         end
         send_transaction(OP_DATA, 8'($urandom), value, 1'($urandom), 1'($urandom),
                          1'($urandom), 4'($urandom));
      end
      // drop the checksum now and then so the next header overrides an open frame
      if (shape != 19)
         send_transaction(OP_CHECKSUM, 8'($urandom),
                          ($urandom_range(0, 4) != 0) ? ~sum : 8'($urandom),
                          1'($urandom), 1'($urandom), 1'($urandom), 4'($urandom));
      framed_count++;
   endtask

   initial begin
      int next_drain_at;
      int directed_count;
      foreach (plan_length[i]) begin
         plan_length[i]   = '0;
         plan_enhanced[i] = 1'b0;
      end
      plan_length[RESET_ID_PLAIN[5:0]]   = RESET_LENGTH;
      plan_length[RESET_ID_REQUEST[5:0]] = RESET_LENGTH;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: no open frame, bad ids, full-length classic frame from the
      // reset table with all-ones bytes and one byte too many
      send_simple(OP_DATA, 8'd0, 8'h00);
      send_simple(OP_CHECKSUM, 8'd0, 8'hFF);
      send_simple(OP_CONFIG, 8'd64, 8'h00);
      send_transaction(OP_CONFIG, 8'd255, 8'hFF, 1'b1, 1'b1, 1'b1, 4'd15);
      send_simple(OP_HEADER, RESET_ID_PLAIN, 8'h00);
      repeat (8) send_simple(OP_DATA, 8'd0, 8'hFF);
      send_simple(OP_DATA, 8'd0, 8'h01);
      send_simple(OP_CHECKSUM, 8'd0, 8'h00);
      // Saturated length, header over an open frame, configure mid-frame,
      // checksum before all bytes
      send_transaction(OP_CONFIG, 8'd0, 8'h00, 1'b1, 1'b1, 1'b1, 4'd2);
      send_transaction(OP_CONFIG, 8'd63, 8'h00, 1'b1, 1'b1, 1'b1, 4'd15);
      send_simple(OP_HEADER, 8'd63, 8'h00);
      send_simple(OP_HEADER, 8'd0, 8'h00);
      send_transaction(OP_CONFIG, 8'd0, 8'h00, 1'b0, 1'b0, 1'b0, 4'd0);
      send_simple(OP_DATA, 8'd0, 8'h80);
      send_simple(OP_CHECKSUM, 8'd0, 8'h55);
      // Request frame from reset, bad-id header closing it, then a zero-length
      // frame with the wrong checksum
      send_simple(OP_HEADER, RESET_ID_REQUEST, 8'h00);
      send_simple(OP_HEADER, 8'd200, 8'h00);
      send_simple(OP_DATA, 8'd0, 8'h12);
      send_simple(OP_HEADER, 8'd0, 8'h00);
      send_simple(OP_CHECKSUM, 8'd0, 8'h00);
      wait_for_responses();
      directed_count = sent_count;

      // Random: mostly framed sequences, the rest noise; flip sender gaps on
      // and off, and drain completely every so often
      next_drain_at = sent_count + DRAIN_INTERVAL;
      while (sent_count < ITEM_TARGET) begin
         if ($urandom_range(0, 9) < 7)
            send_frame();
         else
            send_noise();
         if ($urandom_range(0, 15) == 0)
            gaps_enabled = !gaps_enabled;
         if (sent_count >= next_drain_at) begin
            wait_for_responses();
            next_drain_at = sent_count + DRAIN_INTERVAL;
         end
      end

      wait_for_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      run_complete <= 1'b1;
      repeat (2) @(posedge clock);

      $display("Sent %0d transactions: %0d directed, the rest %0d framed sequences and noise.",
               sent_count, directed_count, framed_count);
      $display("Checked %0d responses under sender gaps and receiver stalls.", received_count);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

FILE: lin_frame_checksum_engine.f
rtl/core/lfce_pkg.sv
rtl/core/lfce_table.sv
rtl/core/lfce_frame.sv
rtl/core/lin_frame_checksum_engine.sv
dv/lfce_frame_checker.sv
dv/lin_frame_checksum_engine_test.sv
